// ----- rtl/mips32_tlb_translate_unit_macros.svh -----
// assertion macros shared by the tlb translate unit rtl
// expects clk and rst to be visible in the module that uses them
`ifndef MIPS32_TLB_TRANSLATE_UNIT_MACROS_SVH
`define MIPS32_TLB_TRANSLATE_UNIT_MACROS_SVH

// implication checked at every clock edge outside reset
`define MTLB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// plain invariant checked at every clock edge outside reset
`define MTLB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`endif

// ----- rtl/mtlb_pkg.sv -----
// types, constants and codes for the tlb translate unit
// no dependencies; used by every module of the block
`default_nettype none

package mtlb_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

  // command codes
  localparam logic [1:0] CMD_XLATE = 2'd0;
  localparam logic [1:0] CMD_PROBE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_WRITE = 2'd3;

  // translate status codes
  localparam logic [2:0] ST_DIRECT   = 3'd0;
  localparam logic [2:0] ST_HIT      = 3'd1;
  localparam logic [2:0] ST_INVALID  = 3'd2;
  localparam logic [2:0] ST_REFILL   = 3'd3;
  localparam logic [2:0] ST_ADDR_ERR = 3'd4;

  // kseg0/kseg1-style unmapped segment selector in vaddr[31:30]
  localparam logic [1:0] SEG_DIRECT = 2'b10;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] vaddr;
    logic        user_mode;
    logic        error_level;
    logic [7:0]  cur_asid;
    logic [3:0]  entry_index;
    logic [25:0] lo_even;
    logic [25:0] lo_odd;
  } in_t;

  typedef struct packed {
    logic [2:0]  xlate_status;
    logic [31:0] phys_addr;
    logic        page_dirty;
    logic        probe_miss;
    logic [3:0]  found_index;
    logic [18:0] rd_vpn2;
    logic [7:0]  rd_asid;
    logic [25:0] rd_lo_even;
    logic [25:0] rd_lo_odd;
  } out_t;

  typedef struct packed {
    logic [18:0] vpn2;
    logic [7:0]  asid;
    logic        glob;
  } tag_t;

  typedef struct packed {
    logic [19:0] pfn;
    logic [2:0]  cache;
    logic        dirty;
    logic        valid;
  } page_t;

  // entry write broadcast to all cells
  typedef struct packed {
    logic        en;
    logic [3:0]  idx;
    tag_t        tag;
    page_t       even;
    page_t       odd;
  } wr_t;

  // lookup token travelling down the cell row
  typedef struct packed {
    logic             active;
    logic [1:0]       cmd;
    logic [31:0]      vaddr;
    logic             user_mode;
    logic             error_level;
    logic [7:0]       cur_asid;
    logic [3:0]       entry_index;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    tag_t             tag;
    page_t            even;
    page_t            odd;
  } tok_t;

endpackage

`default_nettype wire

// ----- rtl/mtlb_cell.sv -----
// one tlb entry plus one stage of the lookup token chain
// depends on mtlb_pkg
`default_nettype none

module mtlb_cell (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    advance,
  input  wire logic [mtlb_pkg::IDX_W-1:0] cell_id,
  input  wire mtlb_pkg::wr_t           wr,
  input  wire mtlb_pkg::tok_t          tok_in,
  output mtlb_pkg::tok_t               tok_out
);
  import mtlb_pkg::*;

  tag_t  tag;
  page_t even_pg;
  page_t odd_pg;
  tok_t  tok_next;
  logic  id_hit;
  logic  vpn_ok;
  logic  asid_ok;
  logic  capture;

  // entry storage, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      tag     <= '0;
      even_pg <= '0;
      odd_pg  <= '0;
    end else if (wr.en && (32'(wr.idx) == 32'(cell_id))) begin
      tag     <= wr.tag;
      even_pg <= wr.even;
      odd_pg  <= wr.odd;
    end
  end

  // compare against the passing token
  assign id_hit  = (32'(tok_in.entry_index) == 32'(cell_id));
  assign vpn_ok  = (tag.vpn2 == tok_in.vaddr[31:13]);
  assign asid_ok = tag.glob || (tag.asid == tok_in.cur_asid);

  always_comb begin
    unique case (tok_in.cmd)
      CMD_XLATE, CMD_PROBE: capture = !tok_in.hit && vpn_ok && asid_ok;
      CMD_READ:             capture = id_hit;
      default:              capture = 1'b0;
    endcase
  end

  // first matching cell stamps its entry into the token
  always_comb begin
    tok_next = tok_in;
    if (capture) begin
      tok_next.hit     = 1'b1;
      tok_next.hit_idx = cell_id;
      tok_next.tag     = tag;
      tok_next.even    = even_pg;
      tok_next.odd     = odd_pg;
    end
  end

  // token stage, only the active flag is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else if (advance) begin
      tok_out.active <= tok_next.active;
    end
    if (advance) begin
      tok_out.cmd         <= tok_next.cmd;
      tok_out.vaddr       <= tok_next.vaddr;
      tok_out.user_mode   <= tok_next.user_mode;
      tok_out.error_level <= tok_next.error_level;
      tok_out.cur_asid    <= tok_next.cur_asid;
      tok_out.entry_index <= tok_next.entry_index;
      tok_out.hit         <= tok_next.hit;
      tok_out.hit_idx     <= tok_next.hit_idx;
      tok_out.tag         <= tok_next.tag;
      tok_out.even        <= tok_next.even;
      tok_out.odd         <= tok_next.odd;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mtlb_result.sv -----
// result formatting and output register for the tlb translate unit
// depends on mtlb_pkg
`default_nettype none

module mtlb_result (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mtlb_pkg::tok_t tail,
  input  wire logic           out_stall,
  output logic                ready,
  output logic                out_valid,
  output mtlb_pkg::out_t      out_data
);
  import mtlb_pkg::*;

  out_t  res;
  page_t pg;
  logic  mapped;
  logic  load;

  // output register free or being emptied this cycle
  assign ready = !out_valid || !out_stall;
  assign load  = tail.active && ready;

  assign pg = tail.vaddr[12] ? tail.odd : tail.even;

  // segment class and per-command result
  always_comb begin
    res    = '0;
    mapped = tail.user_mode ||
             !((tail.vaddr[31:30] == SEG_DIRECT) || tail.error_level);
    unique case (tail.cmd)
      CMD_XLATE: begin
        if (tail.user_mode && tail.vaddr[31]) begin
          res.xlate_status = ST_ADDR_ERR;
        end else if (!mapped) begin
          res.xlate_status = ST_DIRECT;
        end else if (!tail.hit) begin
          res.xlate_status = ST_REFILL;
        end else begin
          res.page_dirty = pg.dirty;
          if (pg.valid) begin
            res.xlate_status = ST_HIT;
            res.phys_addr    = {pg.pfn, tail.vaddr[11:0]};
          end else begin
            res.xlate_status = ST_INVALID;
          end
        end
      end
      CMD_PROBE: begin
        if (tail.hit) begin
          res.found_index = 4'(tail.hit_idx);
        end else begin
          res.probe_miss = 1'b1;
        end
      end
      CMD_READ: begin
        if (tail.hit) begin
          res.rd_vpn2    = tail.tag.vpn2;
          res.rd_asid    = tail.tag.asid;
          res.rd_lo_even = {tail.even, tail.tag.glob};
          res.rd_lo_odd  = {tail.odd, tail.tag.glob};
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mips32_tlb_translate_unit.sv -----
// MIPS32-style joint TLB with 4 KB page pairs: translate, probe, read and write
// one input beat in flight at a time, walking a row of TLB_ENTRIES entry cells; the
// next beat is taken only once the result of the last one has been registered, so
// the command rate is set by the length of the cell row. Writes land in the entry at
// the edge
// the beat is taken. The output register lets the next command run while a result
// waits; a finished token parks in the last cell until the output register frees up.
// Depends on mtlb_pkg, mtlb_cell, mtlb_result and the assertion macro header.
`default_nettype none

`include "mips32_tlb_translate_unit_macros.svh"

module mips32_tlb_translate_unit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire mtlb_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output mtlb_pkg::out_t      out_data
);
  import mtlb_pkg::*;

  tok_t                   chain [TLB_ENTRIES+1];
  logic [TLB_ENTRIES-1:0] act_vec;
  wr_t                    wr;
  tok_t                   tail;
  logic                   in_accept;
  logic                   res_ready;
  logic                   advance;
  logic                   retire;
  logic                   inflight;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = inflight;
  assign tail      = chain[TLB_ENTRIES];
  assign advance   = !tail.active || res_ready;
  assign retire    = tail.active && res_ready;

  // token injected at the head of the row
  always_comb begin
    chain[0]             = '0;
    chain[0].active      = in_accept;
    chain[0].cmd         = in_data.cmd;
    chain[0].vaddr       = in_data.vaddr;
    chain[0].user_mode   = in_data.user_mode;
    chain[0].error_level = in_data.error_level;
    chain[0].cur_asid    = in_data.cur_asid;
    chain[0].entry_index = in_data.entry_index;
  end

  // entry write broadcast
  always_comb begin
    wr.en        = in_accept && (in_data.cmd == CMD_WRITE);
    wr.idx       = in_data.entry_index;
    wr.tag.vpn2  = in_data.vaddr[31:13];
    wr.tag.asid  = in_data.cur_asid;
    wr.tag.glob  = in_data.lo_even[0] & in_data.lo_odd[0];
    wr.even      = page_t'(in_data.lo_even[25:1]);
    wr.odd       = page_t'(in_data.lo_odd[25:1]);
  end

  // row of entry cells
  for (genvar g = 0; g < TLB_ENTRIES; g++) begin : g_cell
    mtlb_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .cell_id (IDX_W'(g)),
      .wr      (wr),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
    assign act_vec[g] = chain[g+1].active;
  end

  mtlb_result u_result (
    .clk       (clk),
    .rst       (rst),
    .tail      (tail),
    .out_stall (out_stall),
    .ready     (res_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // one command in flight until its result is registered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 1'b0;
    end else if (in_accept) begin
      inflight <= 1'b1;
    end else if (retire) begin
      inflight <= 1'b0;
    end
  end

  `MTLB_ASSERT_ALWAYS(a_one_token, $onehot0(act_vec), "more than one token in the cell row")
  `MTLB_ASSERT_ALWAYS(a_busy_track, inflight == (act_vec != '0), "busy flag lost its token")
  `MTLB_ASSERT_IMP(a_result_src, $rose(out_valid), $past(tail.active), "result without token")
  `MTLB_ASSERT_IMP(a_park, $past(tail.active && !res_ready), tail.active && $stable(act_vec), "token moved while parked")

endmodule

`default_nettype wire
